@@ src/ppp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the pinhole point projection block.
// No dependencies; every other file in src imports this package.
package ppp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int OUT_BITS      = 32;
   localparam int CSR_COUNT     = 6;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int CAM_VALUES    = 12;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_AX_AY = 3'd0,
      CSR_AZ_BX = 3'd1,
      CSR_BY_BZ = 3'd2,
      CSR_CX_CY = 3'd3,
      CSR_CZ_EX = 3'd4,
      CSR_EY_EZ = 3'd5
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] CSR_RESET [CSR_COUNT] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_FFFF_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000
   };

   typedef struct packed {
      logic valid;
      logic visible;
   } pipe_ctl_type;

endpackage

@@ src/ppp_front.sv @@
`timescale 1ns / 1ps
// Front end of the projection: eye offset, camera cross products, split
// products, the four exact dot products and the visibility test, over five register stages. Uses ppp_pkg.
module ppp_front #(
   parameter int WORD_BITS = ppp_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [WORD_BITS-1:0]   point [3],
   input  logic signed [WORD_BITS-1:0]   cam [ppp_pkg::CAM_VALUES],
   output ppp_pkg::pipe_ctl_type         out_ctl,
   output logic signed [3*WORD_BITS+3:0] out_q [3],
   output logic signed [3*WORD_BITS+3:0] out_det
);
   import ppp_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int W1 = W + 1;
   localparam int PW2 = 2 * W;
   localparam int MW = 2 * W + 1;
   localparam int PW = 2 * W + 2;
   localparam int QW = 3 * W + 4;

   // Stage 1: eye offset and the raw minor products.
   logic signed [W1-1:0]  d1_ff [3], d1_in [3];
   logic signed [W-1:0]   a1_ff [3];
   logic signed [PW2-1:0] pp1_ff [9], pp1_in [9];
   logic signed [PW2-1:0] pn1_ff [9], pn1_in [9];
   logic                  v1_ff;

   // Stage 2: minors.
   logic signed [MW-1:0]  m2_ff [9], m2_in [9];
   logic signed [W1-1:0]  d2_ff [3];
   logic signed [W1-1:0]  a2_ff [3];
   logic                  v2_ff;

   // Stage 3: partial products, high and low half of each minor.
   logic signed [PW-1:0]  ph3_ff [12], ph3_in [12];
   logic signed [PW-1:0]  pl3_ff [12], pl3_in [12];
   logic                  v3_ff;

   // Stage 4: dot products q0, q1, q2 and det.
   logic signed [QW-1:0]  s4_ff [4], s4_in [4];
   logic                  v4_ff;

   // Stage 5: visibility test.
   logic signed [QW-1:0]  q5_ff [3];
   logic signed [QW-1:0]  det5_ff;
   pipe_ctl_type          ctl5_ff, ctl5_in;

   always_comb begin
      int ui, vi;
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = W1'(point[i]) - W1'(cam[9 + i]);
      end
      // Minor group g is (u x v) with u = vector (g+1) mod 3 and v = vector (g+2) mod 3, giving b x c,
      // c x a and a x b in turn. Vector k component j sits at cam[3k + j].
      for (int g = 0; g < 3; g++) begin
         ui = 3 * ((g + 1) % 3);
         vi = 3 * ((g + 2) % 3);
         for (int i = 0; i < 3; i++) begin
            pp1_in[3*g+i] = PW2'(cam[ui + (i + 1) % 3]) * PW2'(cam[vi + (i + 2) % 3]);
            pn1_in[3*g+i] = PW2'(cam[ui + (i + 2) % 3]) * PW2'(cam[vi + (i + 1) % 3]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         m2_in[k] = MW'(pp1_ff[k]) - MW'(pn1_ff[k]);
      end
   end

   always_comb begin
      int mb;
      logic signed [W1-1:0] hi, lo, x;
      mb = 0;
      hi = '0;
      lo = '0;
      x  = '0;
      // Dots 0 to 2 take the minor groups against d; dot 3 is det = a . (b x c).
      for (int k = 0; k < 4; k++) begin
         mb = (k == 3) ? 0 : 3 * k;
         for (int j = 0; j < 3; j++) begin
            hi = signed'(m2_ff[mb + j][MW-1:W]);
            lo = signed'({1'b0, m2_ff[mb + j][W-1:0]});
            x  = (k == 3) ? a2_ff[j] : d2_ff[j];
            ph3_in[3*k+j] = PW'(hi) * PW'(x);
            pl3_in[3*k+j] = PW'(lo) * PW'(x);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s4_in[k] = '0;
         for (int j = 0; j < 3; j++) begin
            s4_in[k] = s4_in[k] + (QW'(ph3_ff[3*k+j]) <<< W) + QW'(pl3_ff[3*k+j]);
         end
      end
   end

   always_comb begin
      ctl5_in.valid   = v4_ff;
      ctl5_in.visible = (s4_ff[2] != '0) && (s4_ff[3] != '0)
                        && (s4_ff[2][QW-1] == s4_ff[3][QW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         ctl5_ff <= '0;
      end else begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         ctl5_ff <= ctl5_in;
      end
      d1_ff   <= d1_in;
      a1_ff   <= cam[0:2];
      pp1_ff  <= pp1_in;
      pn1_ff  <= pn1_in;
      m2_ff   <= m2_in;
      d2_ff   <= d1_ff;
      for (int i = 0; i < 3; i++) begin
         a2_ff[i] <= W1'(a1_ff[i]);
      end
      ph3_ff  <= ph3_in;
      pl3_ff  <= pl3_in;
      s4_ff   <= s4_in;
      q5_ff   <= s4_ff[0:2];
      det5_ff <= s4_ff[3];
   end

   assign out_ctl = ctl5_ff;
   assign out_q   = q5_ff;
   assign out_det = det5_ff;

endmodule

@@ src/ppp_div.sv @@
`timescale 1ns / 1ps
// Pipelined signed divider: (num << FRAC_BITS) / den truncated toward zero and
// saturated to the word range, one quotient bit per stage; zero when not visible. Uses ppp_pkg.
module ppp_div #(
   parameter int WORD_BITS = ppp_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ppp_pkg::pipe_ctl_type              in_ctl,
   input  logic signed [3*WORD_BITS+3:0]      num,
   input  logic signed [3*WORD_BITS+3:0]      den,
   output logic                               out_valid,
   output logic                               out_visible,
   output logic signed [ppp_pkg::OUT_BITS-1:0] out_quot
);
   import ppp_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int QW = 3 * W + 4;
   localparam int SH = (W > FRAC_BITS) ? W : FRAC_BITS;
   localparam int RW = QW + SH;

   logic [RW-1:0] rem_ff [0:W];
   logic [W-1:0]  quo_ff [0:W];
   logic [QW-1:0] md_ff  [0:W];
   logic          neg_ff [0:W];
   logic          sat_ff [0:W];
   logic          vis_ff [0:W];
   logic          val_ff [0:W];

   logic [QW-1:0] mn_in, md_in;
   logic [RW-1:0] rem0_in;
   logic          sat_in;

   always_comb begin
      mn_in   = num[QW-1] ? QW'(-num) : QW'(num);
      md_in   = den[QW-1] ? QW'(-den) : QW'(den);
      rem0_in = RW'(mn_in) << FRAC_BITS;
      // A quotient of 2^W or more saturates whatever its sign.
      sat_in  = rem0_in >= (RW'(md_in) << W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else begin
         val_ff[0] <= in_ctl.valid;
      end
      rem_ff[0] <= rem0_in;
      quo_ff[0] <= '0;
      md_ff[0]  <= md_in;
      neg_ff[0] <= num[QW-1] ^ den[QW-1];
      sat_ff[0] <= sat_in;
      vis_ff[0] <= in_ctl.visible;
   end

   for (genvar s = 1; s <= W; s++) begin : g_step
      logic [RW-1:0] dsh;
      logic [RW:0]   diff;

      always_comb begin
         dsh  = RW'(md_ff[s-1]) << (W - s);
         diff = {1'b0, rem_ff[s-1]} - {1'b0, dsh};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else begin
            val_ff[s] <= val_ff[s-1];
         end
         rem_ff[s] <= diff[RW] ? rem_ff[s-1] : diff[RW-1:0];
         quo_ff[s] <= {quo_ff[s-1][W-2:0], ~diff[RW]};
         md_ff[s]  <= md_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         sat_ff[s] <= sat_ff[s-1];
         vis_ff[s] <= vis_ff[s-1];
      end
   end

   logic [W-1:0]          lim, mag;
   logic signed [W-1:0]   res;
   logic signed [OUT_BITS-1:0] quot_in, quot_ff;
   logic                  valid_ff, visible_ff;

   always_comb begin
      lim     = {neg_ff[W], {(W-1){~neg_ff[W]}}};
      mag     = (sat_ff[W] || (quo_ff[W] > lim)) ? lim : quo_ff[W];
      res     = neg_ff[W] ? signed'(-mag) : signed'(mag);
      quot_in = vis_ff[W] ? OUT_BITS'(res) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= val_ff[W];
      end
      quot_ff    <= quot_in;
      visible_ff <= vis_ff[W];
   end

   assign out_valid   = valid_ff;
   assign out_visible = visible_ff;
   assign out_quot    = quot_ff;

endmodule

@@ src/pinhole_point_projection.sv @@
`timescale 1ns / 1ps
// Top level of the pinhole point projection block: camera registers, the
// front end and three dividers. Depends on ppp_pkg, ppp_front and ppp_div.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low; it carries one world point (req_point_x/y/z). Exactly one response
// follows: rsp_valid is high for a single cycle with rsp_screen_u,
// rsp_screen_v, rsp_inv_depth and rsp_visible. The receiver cannot hold it
// off, so the pipeline never stalls.
// The response passes WORD_BITS + 7 register stages: five front-end stages,
// one preparation stage, one stage per quotient bit in the dividers and an
// output register. The first stage loads at the accepting edge. A new
// request may be taken every cycle; busy is raised only during reset and the
// cycle after it.
// The camera is written through csr_we, csr_index and csr_wdata, one register
// per cycle; the user must write it only while no request is in flight, which
// the block itself does not enforce. Reset loads the default camera, whose
// corner vector is zero, so points read as not visible until the camera is
// set up. Writes to an index beyond the last register are dropped.
module pinhole_point_projection #(
   parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = ppp_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [31:0]                    req_point_x,
   input  logic signed [31:0]                    req_point_y,
   input  logic signed [31:0]                    req_point_z,
   output logic                                  rsp_valid,
   output logic signed [ppp_pkg::OUT_BITS-1:0]   rsp_screen_u,
   output logic signed [ppp_pkg::OUT_BITS-1:0]   rsp_screen_v,
   output logic signed [ppp_pkg::OUT_BITS-1:0]   rsp_inv_depth,
   output logic                                  rsp_visible,
   input  logic                                  csr_we,
   input  logic [ppp_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [ppp_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import ppp_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int QW  = 3 * W + 4;
   localparam int LAT = W + 7;

   logic [CSR_DATA_BITS-1:0] csr_ff [CSR_COUNT];
   logic                     busy_ff;
   logic                     accept;

   logic signed [W-1:0]  point [3];
   logic signed [W-1:0]  cam [CAM_VALUES];
   pipe_ctl_type         front_ctl;
   logic signed [QW-1:0] front_q [3];
   logic signed [QW-1:0] front_det;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         csr_ff  <= CSR_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_AX_AY: csr_ff[0] <= csr_wdata;
               CSR_AZ_BX: csr_ff[1] <= csr_wdata;
               CSR_BY_BZ: csr_ff[2] <= csr_wdata;
               CSR_CX_CY: csr_ff[3] <= csr_wdata;
               CSR_CZ_EX: csr_ff[4] <= csr_wdata;
               CSR_EY_EZ: csr_ff[5] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Each register holds two values; only the low WORD_BITS of each half count.
   always_comb begin
      for (int k = 0; k < CAM_VALUES; k++) begin
         cam[k] = signed'(csr_ff[k / 2][32 * (k % 2) +: W]);
      end
      point[0] = signed'(req_point_x[W-1:0]);
      point[1] = signed'(req_point_y[W-1:0]);
      point[2] = signed'(req_point_z[W-1:0]);
   end

   ppp_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .point    (point),
      .cam      (cam),
      .out_ctl  (front_ctl),
      .out_q    (front_q),
      .out_det  (front_det)
   );

   ppp_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div_u (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (front_ctl),
      .num         (front_q[0]),
      .den         (front_q[2]),
      .out_valid   (rsp_valid),
      .out_visible (rsp_visible),
      .out_quot    (rsp_screen_u)
   );

   ppp_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div_v (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (front_ctl),
      .num         (front_q[1]),
      .den         (front_q[2]),
      .out_valid   (),
      .out_visible (),
      .out_quot    (rsp_screen_v)
   );

   ppp_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div_depth (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (front_ctl),
      .num         (front_det),
      .den         (front_q[2]),
      .out_valid   (),
      .out_visible (),
      .out_quot    (rsp_inv_depth)
   );

   // Every response must trace back to exactly one earlier accepted request.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without a matching request");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_visible) |->
         (rsp_screen_u == '0 && rsp_screen_v == '0 && rsp_inv_depth == '0))
      else $error("hidden point with nonzero result fields");

   // det and q2 share a sign for a visible point, so the depth term is never negative.
   a_depth_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_visible) |-> !rsp_inv_depth[OUT_BITS-1])
      else $error("negative inverse depth on a visible point");

endmodule

@@ sim/tb_pinhole_point_projection.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pinhole_point_projection: drives random and
// directed world points under several cameras and compares every response
// against its own exact projection. Depends on ppp_pkg and the src RTL.
module tb_pinhole_point_projection;
   import ppp_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int LATENCY    = WORD_BITS_DEF + 6;
   localparam int CYCLE_MAX  = 400000;
   localparam int RAND_ITEMS = 1300;

   typedef struct {
      logic signed [31:0] screen_u;
      logic signed [31:0] screen_v;
      logic signed [31:0] inv_depth;
      logic               visible;
   } view_type;

   class projection_scoreboard;
      logic [CSR_DATA_BITS-1:0] camera [CSR_COUNT];
      view_type expected_views [$];
      int mismatches;
      int unexpected;
      int checked;
      int visible_seen;

      function new();
         foreach (camera[i]) camera[i] = CSR_RESET[i];
         mismatches = 0;
         unexpected = 0;
         checked = 0;
         visible_seen = 0;
      endfunction

      function void write_reg(int idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx < CSR_COUNT) camera[idx] = data;
      endfunction

      // Camera value k in order ax ay az bx by bz cx cy cz ex ey ez.
      function logic signed [127:0] cam_value(int k);
         logic [31:0] half;
         half = (k % 2) ? camera[k / 2][63:32] : camera[k / 2][31:0];
         return $signed(half);
      endfunction

      function logic signed [31:0] quotient_sat(logic signed [127:0] num,
                                                 logic signed [127:0] den);
         logic signed [127:0] t;
         t = (num <<< FRAC) / den;
         if (t > 128'sd2147483647) return 32'h7FFF_FFFF;
         if (t < -128'sd2147483648) return 32'h8000_0000;
         return t[31:0];
      endfunction

      function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
         logic signed [127:0] a [3], b [3], c [3], d [3], bc [3], ca [3], ab [3];
         logic signed [127:0] p [3];
         logic signed [127:0] q0, q1, q2, det;
         view_type res;
         p[0] = px;
         p[1] = py;
         p[2] = pz;
         for (int i = 0; i < 3; i++) begin
            a[i] = cam_value(i);
            b[i] = cam_value(3 + i);
            c[i] = cam_value(6 + i);
            d[i] = p[i] - cam_value(9 + i);
         end
         bc[0] = b[1] * c[2] - b[2] * c[1];
         bc[1] = b[2] * c[0] - b[0] * c[2];
         bc[2] = b[0] * c[1] - b[1] * c[0];
         ca[0] = c[1] * a[2] - c[2] * a[1];
         ca[1] = c[2] * a[0] - c[0] * a[2];
         ca[2] = c[0] * a[1] - c[1] * a[0];
         ab[0] = a[1] * b[2] - a[2] * b[1];
         ab[1] = a[2] * b[0] - a[0] * b[2];
         ab[2] = a[0] * b[1] - a[1] * b[0];
         q0 = bc[0] * d[0] + bc[1] * d[1] + bc[2] * d[2];
         q1 = ca[0] * d[0] + ca[1] * d[1] + ca[2] * d[2];
         q2 = ab[0] * d[0] + ab[1] * d[1] + ab[2] * d[2];
         det = a[0] * bc[0] + a[1] * bc[1] + a[2] * bc[2];
         res = '{0, 0, 0, 1'b0};
         if (q2 != 0 && det != 0 && (q2 < 0) == (det < 0)) begin
            res.screen_u = quotient_sat(q0, q2);
            res.screen_v = quotient_sat(q1, q2);
            res.inv_depth = quotient_sat(det, q2);
            res.visible = 1'b1;
         end
         expected_views = {expected_views, res};
      endfunction

      function void check_result(view_type got);
         view_type want;
         if (expected_views.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: response with no request outstanding");
            return;
         end
         want = expected_views.pop_front();
         checked++;
         if (got.visible) visible_seen++;
         if (got.screen_u !== want.screen_u || got.screen_v !== want.screen_v ||
             got.inv_depth !== want.inv_depth || got.visible !== want.visible) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: exp u=%h v=%h w=%h vis=%b got u=%h v=%h w=%h vis=%b",
                        want.screen_u, want.screen_v, want.inv_depth, want.visible,
                        got.screen_u, got.screen_v, got.inv_depth, got.visible);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic rsp_valid;
   logic signed [OUT_BITS-1:0] rsp_screen_u, rsp_screen_v, rsp_inv_depth;
   logic rsp_visible;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   projection_scoreboard board = new();
   int cycles = 0;
   int idle_pct = 30;
   int camera_settings = 0;

   pinhole_point_projection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .rsp_valid(rsp_valid),
      .rsp_screen_u(rsp_screen_u), .rsp_screen_v(rsp_screen_v),
      .rsp_inv_depth(rsp_inv_depth), .rsp_visible(rsp_visible),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result('{rsp_screen_u, rsp_screen_v, rsp_inv_depth, rsp_visible});
   end

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Writes all six camera registers: vectors a, b, c and the eye centre.
   task automatic set_camera(logic [31:0] v [12]);
      write_csr(CSR_AX_AY, {v[1], v[0]});
      write_csr(CSR_AZ_BX, {v[3], v[2]});
      write_csr(CSR_BY_BZ, {v[5], v[4]});
      write_csr(CSR_CX_CY, {v[7], v[6]});
      write_csr(CSR_CZ_EX, {v[9], v[8]});
      write_csr(CSR_EY_EZ, {v[11], v[10]});
      camera_settings++;
   endtask

   task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_point_x = px;
      req_point_y = py;
      req_point_z = pz;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      board.note_point(px, py, pz);
   endtask

   // Lets every outstanding request come back, then a margin for the pipeline.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (board.expected_views.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int spread);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom_range(0, 2 * spread)) - spread;
      endcase
   endfunction

   task automatic random_points(int count, int spread);
      for (int n = 0; n < count; n++)
         send_point(rand_coord(spread), rand_coord(spread), rand_coord(spread));
   endtask

   logic [31:0] cam_vals [12];

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset camera is degenerate, so nothing is visible.
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      drain();

      // A plain camera looking down +z; indexes past the last register are dropped.
      cam_vals = '{32'h0001_0000, 0, 0, 0, 32'hFFFF_0000, 0,
                   32'hFF60_0000, 32'h0078_0000, 32'h0064_0000, 0, 0, 0};
      set_camera(cam_vals);
      write_csr(CSR_IDX_BITS'(CSR_COUNT), {64{1'b1}});
      write_csr(CSR_IDX_BITS'(CSR_COUNT + 1), {64{1'b1}});
      send_point(0, 0, 32'h0001_0000);
      send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0002_0000);
      send_point(32'h0001_0000, 32'h0001_0000, 0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(0, 0, 32'h7FFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      drain();

      // Cameras at the register extremes.
      foreach (cam_vals[i]) cam_vals[i] = 32'h7FFF_FFFF;
      cam_vals[4] = 32'h8000_0000;
      cam_vals[8] = 32'h8000_0000;
      set_camera(cam_vals);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      random_points(20, 1 << 24);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         // Small perturbed cameras give visible points; fully random ones stress saturation.
         cam_vals = '{32'h0001_0000, 0, 0, 0, 32'hFFFF_0000, 0,
                      32'hFF60_0000, 32'h0078_0000, 32'h0064_0000, 0, 0, 0};
         foreach (cam_vals[i])
            if (phase % 3 == 2) cam_vals[i] = $urandom();
            else cam_vals[i] = cam_vals[i] + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
         set_camera(cam_vals);
         idle_pct = (phase == 3 || phase == 4) ? 0 : 30;
         random_points(RAND_ITEMS / 8, 1 << (20 + phase));
         drain();
      end

      $display("Checked %0d responses (%0d visible) across %0d camera settings.",
               board.checked, board.visible_seen, camera_settings);
      if (board.mismatches == 0 && board.unexpected == 0 &&
          board.expected_views.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d unexpected responses", board.mismatches,
                  board.unexpected);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
